// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i while rst_ni is high.
`define SMPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle leads to another condition in the next cycle.
`define SMPQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/smpq_pkg.sv =====
`timescale 1ns / 1ps

package smpq_pkg;

  // Queue geometry.
  localparam int unsigned Depth    = 16;
  localparam int unsigned KeyBytes = 8;
  localparam int unsigned KeyW     = 8 * KeyBytes;
  localparam int unsigned CntW     = $clog2(Depth + 1);

  // Port widths that are fixed by the interface.
  localparam int unsigned KeyPortW = 64;
  localparam int unsigned CntPortW = 5;

  typedef logic [KeyW-1:0] key_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain at once.
  typedef struct packed {
    logic en;
    op_e  op;
    key_t key;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/smpq_cell.sv =====
`timescale 1ns / 1ps

module smpq_cell (
  input  logic               clk_i,
  input  smpq_pkg::cell_cmd_t cmd_i,
  input  logic               occupied_i,
  input  logic               prev_lt_i,
  input  smpq_pkg::key_t     prev_key_i,
  input  smpq_pkg::key_t     next_key_i,
  output logic               lt_o,
  output smpq_pkg::key_t     key_o
);
  import smpq_pkg::*;

  key_t key_q, key_d;

  // The new key goes in front of this slot if the slot is empty or holds a
  // strictly larger key, so equal keys keep their arrival order.
  assign lt_o = !occupied_i || (cmd_i.key < key_q);

  // Insert shifts the tail of the list one slot up; remove shifts it down.
  always_comb begin
    key_d = key_q;
    if (cmd_i.en) begin
      if (cmd_i.op == OpInsert) begin
        if (prev_lt_i) begin
          key_d = prev_key_i;
        end else if (lt_o) begin
          key_d = cmd_i.key;
        end
      end else begin
        key_d = next_key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

// ===== hw/rtl/sorted_min_priority_queue_core.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_ready_o | op_i, key_i
// result  | out       | out_valid_o/out_ready_i | removed_key_o, min_key_o, count_o, status_o
//
// Every accepted item, but a dropped insert or an empty remove, updates a chain of
// Depth key cells and its result is registered, so one item per cycle is taken while
// the result slot is free or being read in the same cycle. The result appears in the
// cycle after the item is accepted. Reset empties the queue at once by clearing the
// entry count. A stalled result blocks further items until it is taken.

module sorted_min_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [63:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] removed_key_o,
  output logic [63:0] min_key_o,
  output logic [4:0]  count_o,
  output logic [1:0]  status_o
);
  import smpq_pkg::*;

  cnt_t      count_q, count_d;
  logic      out_valid_q;
  key_t      removed_q, removed_d;
  key_t      min_q, min_d;
  status_e   status_q, status_d;
  cell_cmd_t cmd;
  logic      accept;
  logic      full, empty;

  key_t        cell_key [Depth];
  logic        cell_lt  [Depth];
  logic        cell_occ [Depth];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == cnt_t'(Depth));
  assign empty      = (count_q == '0);

  // Command for the chain; a dropped insert or an empty remove leaves it alone.
  always_comb begin
    cmd.op  = op_e'(op_i);
    cmd.key = key_t'(key_i);
    cmd.en  = accept && ((cmd.op == OpInsert) ? !full : !empty);
  end

  // Chain of key cells, slot 0 holding the minimum.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic prev_lt;
    key_t prev_key;
    key_t next_key;

    assign cell_occ[i] = (count_q > cnt_t'(i));

    if (i == 0) begin : g_head
      assign prev_lt  = 1'b0;
      assign prev_key = '0;
    end else begin : g_body
      assign prev_lt  = cell_lt[i-1];
      assign prev_key = cell_key[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_key = '0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    smpq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (cell_occ[i]),
      .prev_lt_i  (prev_lt),
      .prev_key_i (prev_key),
      .next_key_i (next_key),
      .lt_o       (cell_lt[i]),
      .key_o      (cell_key[i])
    );
  end

  // Result of the step and the new entry count.
  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    min_d     = empty ? '0 : cell_key[0];
    status_d  = StOk;
    if (cmd.op == OpInsert) begin
      if (full) begin
        status_d = StFull;
      end else begin
        count_d = count_q + cnt_t'(1);
        min_d   = cell_lt[0] ? cmd.key : cell_key[0];
      end
    end else begin
      if (empty) begin
        status_d = StEmpty;
      end else begin
        count_d   = count_q - cnt_t'(1);
        removed_d = cell_key[0];
        min_d     = cell_occ[1] ? cell_key[1] : '0;
      end
    end
  end

  // Control state: entry count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      min_q     <= min_d;
      status_q  <= status_d;
    end
  end

  // The count register already holds the count after the latest item.
  assign out_valid_o   = out_valid_q;
  assign removed_key_o = KeyPortW'(removed_q);
  assign min_key_o     = KeyPortW'(min_q);
  assign count_o       = CntPortW'(count_q);
  assign status_o      = status_q;

endmodule

// ===== hw/rtl/smpq_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module smpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] removed_key_o,
  input logic [63:0] min_key_o,
  input logic [4:0]  count_o,
  input logic [1:0]  status_o
);
  import smpq_pkg::*;

  // A stalled result keeps its fields.
  `SMPQ_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i,
    out_valid_o && $stable(removed_key_o) && $stable(min_key_o) && $stable(count_o)
    && $stable(status_o), "Stalled result changed")

  // A remove from an empty queue reports an empty queue and no key.
  `SMPQ_ASSERT(a_empty_remove, !(out_valid_o && status_o == StEmpty)
    || (count_o == '0 && removed_key_o == '0 && min_key_o == '0), "Bad empty remove result")

  // A dropped insert only happens on a full queue.
  `SMPQ_ASSERT(a_full_drop, !(out_valid_o && status_o == StFull)
    || (count_o == CntPortW'(Depth) && removed_key_o == '0), "Bad full insert result")

  // An empty queue shows a zero minimum.
  `SMPQ_ASSERT(a_empty_min, !(out_valid_o && count_o == '0) || min_key_o == '0,
    "Nonzero minimum on empty queue")

  // A removed key is never larger than the minimum left behind.
  `SMPQ_ASSERT(a_remove_order, !(out_valid_o && count_o != '0 && removed_key_o != '0)
    || removed_key_o <= min_key_o, "Removed key above remaining minimum")

endmodule

bind sorted_min_priority_queue_core smpq_checker u_smpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .removed_key_o (removed_key_o),
  .min_key_o     (min_key_o),
  .count_o       (count_o),
  .status_o      (status_o)
);

// ===== tb/sorted_min_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_min_priority_queue_core_tb;
  import smpq_pkg::*;

  // One result item as the queue reports it.
  typedef struct {
    logic [63:0] removed_key;
    logic [63:0] min_key;
    logic [4:0]  count;
    status_e     status;
  } queue_result_t;

  // One row of the directed stimulus; exact rows carry a hand-written result.
  typedef struct {
    op_e           op;
    logic [63:0]   key;
    bit            exact;
    queue_result_t want;
  } stim_row_t;

  localparam int DirectedRows = 25;
  localparam int RandomItems  = 750;
  localparam int MaxGap       = 17;
  localparam int StuckLimit   = 1000;
  localparam int DrainCycles  = 10;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam queue_result_t NoCheck = '{64'h0, 64'h0, 5'd0, StOk};

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        op_i        = OpInsert;
  logic [63:0] key_i       = 64'h0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] removed_key_o;
  logic [63:0] min_key_o;
  logic [4:0]  count_o;
  logic [1:0]  status_o;

  // Shadow copy of the queue contents, ascending.
  key_t          shadow_keys [Depth];
  int            shadow_count = 0;
  queue_result_t pending_results [$];
  int            mismatches   = 0;
  bit            sender_fast  = 1'b0;
  bit            reader_fast  = 1'b0;
  int            stuck_cycles = 0;
  stim_row_t     directed_rows [DirectedRows];

  sorted_min_priority_queue_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .removed_key_o (removed_key_o),
    .min_key_o     (min_key_o),
    .count_o       (count_o),
    .status_o      (status_o)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Applies one item to the shadow queue and returns the result it should give.
  function automatic queue_result_t apply_to_shadow(op_e op, logic [63:0] key);
    key_t          k;
    int            pos;
    queue_result_t r;
    k = key_t'(key);
    r = '{64'h0, 64'h0, 5'd0, StOk};
    if (op == OpInsert) begin
      if (shadow_count >= Depth) begin
        r.status = StFull;
      end else begin
        // A new key lands behind every key equal to it.
        pos = 0;
        while (pos < shadow_count && !(k < shadow_keys[pos])) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = k;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = StEmpty;
      end else begin
        r.removed_key = 64'(shadow_keys[0]);
        for (int i = 1; i < shadow_count; i++) shadow_keys[i-1] = shadow_keys[i];
        shadow_count--;
      end
    end
    r.min_key = (shadow_count > 0) ? 64'(shadow_keys[0]) : 64'h0;
    r.count   = 5'(shadow_count);
    return r;
  endfunction

  // Offers one item after a random gap and records its expected result once taken.
  task automatic send_item(input op_e op, input logic [63:0] key, input bit exact,
                           input queue_result_t want);
    int            gap;
    queue_result_t predicted;
    if ($urandom_range(0, 29) == 0) sender_fast = !sender_fast;
    gap = sender_fast ? 0 : $urandom_range(0, MaxGap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_to_shadow(op, key);
    pending_results.push_back(exact ? want : predicted);
  endtask

  // Holds the sender off until every outstanding result has been read.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Picks a key: fully random, a narrow range for duplicates, an extreme,
  // or a copy of a key already held.
  function automatic logic [63:0] pick_key();
    int b;
    b = $urandom_range(0, 63);
    case ($urandom_range(0, 5))
      0, 1: return {$urandom, $urandom};
      2: return 64'($urandom_range(0, 7));
      3: return ($urandom_range(0, 1) != 0) ? (64'h1 << b) : ~(64'h1 << b);
      4: return ($urandom_range(0, 1) != 0) ? AllOnes : 64'h0;
      default: begin
        if (shadow_count > 0) return 64'(shadow_keys[$urandom_range(0, shadow_count - 1)]);
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  // Result side: random stalls, then compare each result with the oldest expectation.
  initial begin
    queue_result_t want;
    int            stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) reader_fast = !reader_fast;
      stall = reader_fast ? 0 : $urandom_range(0, MaxGap);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected (removed %h min %h count %0d status %0d)",
                 $time, removed_key_o, min_key_o, count_o, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (removed_key_o !== want.removed_key) begin
          $display("%0t: removed_key expected %h actual %h", $time, want.removed_key,
                   removed_key_o);
          mismatches++;
        end
        if (min_key_o !== want.min_key) begin
          $display("%0t: min_key expected %h actual %h", $time, want.min_key, min_key_o);
          mismatches++;
        end
        if (count_o !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, count_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StuckLimit);
        $display("sorted_min_priority_queue_core_tb: FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Stimulus: directed rows, then bursts of random inserts and removes.
  initial begin
    int   burst_left;
    int   insert_pct;
    op_e  op;
    directed_rows = '{
      // Remove from an empty queue right after reset.
      '{OpRemove, 64'h0,                  1'b1, '{64'h0, 64'h0, 5'd0, StEmpty}},
      '{OpInsert, AllOnes,                1'b1, '{64'h0, AllOnes, 5'd1, StOk}},
      '{OpInsert, 64'h0,                  1'b1, '{64'h0, 64'h0, 5'd2, StOk}},
      // Duplicate of the largest key, then a spread of values.
      '{OpInsert, AllOnes,                1'b0, NoCheck},
      '{OpInsert, 64'h8000_0000_0000_0000, 1'b0, NoCheck},
      '{OpInsert, 64'h0000_0000_0000_0001, 1'b0, NoCheck},
      '{OpInsert, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NoCheck},
      '{OpInsert, 64'h0123_4567_89AB_CDEF, 1'b0, NoCheck},
      '{OpInsert, 64'h5555_5555_5555_5555, 1'b0, NoCheck},
      '{OpInsert, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NoCheck},
      '{OpInsert, 64'h0,                  1'b0, NoCheck},
      // Zero-padded strings: a prefix sorts before the longer string.
      '{OpInsert, 64'h6162_6300_0000_0000, 1'b0, NoCheck},
      '{OpInsert, 64'h6162_0000_0000_0000, 1'b0, NoCheck},
      '{OpInsert, 64'h6162_6364_0000_0000, 1'b0, NoCheck},
      '{OpInsert, 64'h0000_0000_0000_0001, 1'b0, NoCheck},
      '{OpInsert, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, NoCheck},
      '{OpInsert, 64'h0000_0000_0000_0100, 1'b0, NoCheck},
      // The queue is now full: both inserts are dropped.
      '{OpInsert, 64'h0000_0000_0000_002A, 1'b1, '{64'h0, 64'h0, 5'(Depth), StFull}},
      '{OpInsert, 64'h0,                  1'b1, '{64'h0, 64'h0, 5'(Depth), StFull}},
      '{OpRemove, 64'h0,                  1'b0, NoCheck},
      '{OpRemove, AllOnes,                1'b0, NoCheck},
      '{OpRemove, 64'h0,                  1'b0, NoCheck},
      '{OpRemove, 64'h0,                  1'b0, NoCheck},
      '{OpRemove, 64'h0,                  1'b0, NoCheck},
      '{OpRemove, 64'h0,                  1'b0, NoCheck}
    };

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].exact,
                directed_rows[i].want);
    drain_results();

    // Bursts lean toward inserts or removes so the queue swings between full and empty.
    burst_left = 0;
    insert_pct = 50;
    for (int n = 0; n < RandomItems; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0: insert_pct = $urandom_range(85, 100);
          1: insert_pct = $urandom_range(0, 15);
          default: insert_pct = $urandom_range(30, 70);
        endcase
      end
      burst_left--;
      op = ($urandom_range(0, 99) < insert_pct) ? OpInsert : OpRemove;
      send_item(op, (op == OpInsert) ? pick_key() : {$urandom, $urandom}, 1'b0, NoCheck);
      if (n == RandomItems / 2) drain_results();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("sorted_min_priority_queue_core_tb: PASS");
    end else begin
      $display("sorted_min_priority_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule
